// ----- sv/streaming_top_k_selector_top_macros.svh -----
// Assertion macros for the streaming top-k selector checker.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef STREAMING_TOP_K_SELECTOR_TOP_MACROS_SVH
`define STREAMING_TOP_K_SELECTOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define STKS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("top-k selector: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define STKS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("top-k selector: next-cycle check failed");

`endif

// ----- sv/stks_pkg.sv -----
// Shared types and constants of the streaming top-k selector.
// No dependencies; used by every other file of the block except the macros header.
`default_nettype none

package stks_pkg;

  localparam int unsigned ScoreW      = 32;
  localparam int unsigned PosW        = 18;
  localparam int unsigned KCfgW       = 5;
  localparam int unsigned MaxElements = 262144;

  localparam logic [PosW-1:0]  MaxPos      = PosW'(MaxElements - 1);
  localparam logic [KCfgW-1:0] KInUseReset = 5'd16;

  // input transaction
  typedef struct packed {
    logic signed [ScoreW-1:0] score;
    logic                     last;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [PosW-1:0]          position;
    logic signed [ScoreW-1:0] kept_score;
    logic                     end_of_list;
  } out_t;

  // one kept entry as held in a cell
  typedef struct packed {
    logic signed [ScoreW-1:0] score;
    logic [PosW-1:0]          position;
  } entry_t;

  // broadcast control from the top level to every cell
  typedef struct packed {
    logic   insert;
    logic   emit;
    entry_t incoming;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/stks_cell.sv -----
// One compare-and-shift cell of the top-k chain.
// Depends on stks_pkg.
`default_nettype none

module stks_cell (
  input  logic                clk_i,
  input  stks_pkg::cell_ctrl_t ctrl_i,
  input  logic                valid_i,    // slot holds a kept entry
  input  logic                left_ge_i,  // upper neighbor ranks at or above incoming
  input  stks_pkg::entry_t    left_i,
  input  stks_pkg::entry_t    right_i,
  output logic                ge_o,
  output stks_pkg::entry_t    entry_o
);
  import stks_pkg::*;

  entry_t entry_q, entry_d;

  assign ge_o    = valid_i && (entry_q.score >= ctrl_i.incoming.score);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.emit) begin
      entry_d = right_i;                 // drain toward cell 0
    end else if (ctrl_i.insert && !ge_o) begin
      entry_d = left_ge_i ? ctrl_i.incoming : left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

// ----- sv/streaming_top_k_selector_top.sv -----
// Top level of the streaming top-k selector: cell chain, counters, drain control.
// Depends on stks_pkg and stks_cell.
//
//  channel   direction  handshake                    payload
//  item      in         start & !busy                item_i  (score, last)
//  result    out        result_valid_o, one cycle    result_o (position, kept_score, end_of_list)
//  config    in         cfg_we_i                     cfg_wdata_i (k_in_use)
//
// One score is taken per cycle: every cell compares and shifts in the same cycle,
// so the K-cell chain accepts back-to-back transactions while no result run is active.
// After a transaction with last, busy stays high while the chain drains its n kept entries
// (1..K), one entry per cycle, through cell 0 onto result_o.
// rst_ni clears the kept count, the position counter, the drain control and sets
// k_in_use to 16; cell contents are not reset. The receiver cannot stall results.
`default_nettype none

module streaming_top_k_selector_top #(
  parameter int unsigned K = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  stks_pkg::in_t              item_i,
  output logic                       result_valid_o,
  output stks_pkg::out_t             result_o,
  input  logic                       cfg_we_i,
  input  logic [stks_pkg::KCfgW-1:0] cfg_wdata_i
);
  import stks_pkg::*;

  localparam int unsigned CntW = $clog2(K + 1);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StEmit = 2'b10
  } state_e;

  state_e          state_q, state_d;
  logic [KCfgW-1:0] k_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] left_q, left_d;     // results still to drain
  logic [PosW-1:0] elem_q, elem_d;

  logic [CntW-1:0] k_eff, cnt_eff, cnt_next;
  logic            accept;
  cell_ctrl_t      ctrl;

  logic   [K-1:0] ge;
  entry_t         entries [K];

  assign accept = start && !busy;

  // k clamped to 1..K
  always_comb begin
    if (k_q == '0) begin
      k_eff = CntW'(1);
    end else if (32'(k_q) > K) begin
      k_eff = CntW'(K);
    end else begin
      k_eff = CntW'(k_q);
    end
  end

  // drop entries beyond a lowered k, then grow by one unless full
  assign cnt_eff  = (cnt_q > k_eff) ? k_eff : cnt_q;
  assign cnt_next = (cnt_eff < k_eff) ? cnt_eff + CntW'(1) : cnt_eff;

  assign ctrl.insert            = accept;
  assign ctrl.emit              = (state_q == StEmit);
  assign ctrl.incoming.score    = item_i.score;
  assign ctrl.incoming.position = elem_q;

  // chain of cells; cell 0 holds the largest entry
  for (genvar i = 0; i < K; i++) begin : g_cell
    logic   valid;
    logic   left_ge;
    entry_t left, right;

    assign valid = (CntW'(i) < cnt_eff);

    if (i == 0) begin : g_head
      assign left_ge = 1'b1;
      assign left    = ctrl.incoming;
    end else begin : g_body
      assign left_ge = ge[i-1];
      assign left    = entries[i-1];
    end

    if (i == K - 1) begin : g_tail
      assign right = '0;
    end else begin : g_inner
      assign right = entries[i+1];
    end

    stks_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .valid_i  (valid),
      .left_ge_i(left_ge),
      .left_i   (left),
      .right_i  (right),
      .ge_o     (ge[i]),
      .entry_o  (entries[i])
    );
  end

  // counters and drain sequencing
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    left_d  = left_q;
    elem_d  = elem_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (item_i.last) begin
            state_d = StEmit;
            left_d  = cnt_next;
            cnt_d   = '0;
            elem_d  = '0;
          end else begin
            cnt_d  = cnt_next;
            elem_d = (elem_q != MaxPos) ? elem_q + PosW'(1) : elem_q;
          end
        end
      end
      StEmit: begin
        left_d = left_q - CntW'(1);
        if (left_q == CntW'(1)) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      left_q  <= '0;
      elem_q  <= '0;
      k_q     <= KInUseReset;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      elem_q  <= elem_d;
      if (cfg_we_i) begin
        k_q <= cfg_wdata_i;
      end
    end
  end

  assign busy                 = (state_q == StEmit);
  assign result_valid_o       = busy;
  assign result_o.position    = entries[0].position;
  assign result_o.kept_score  = entries[0].score;
  assign result_o.end_of_list = busy && (left_q == CntW'(1));

endmodule

`default_nettype wire

// ----- sv/stks_checker.sv -----
// Port-level checker for the streaming top-k selector, bound to the top level.
// Depends on stks_pkg and streaming_top_k_selector_top_macros.svh.
`default_nettype none

`include "streaming_top_k_selector_top_macros.svh"

module stks_checker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  input  wire logic                       busy,
  input  wire stks_pkg::in_t              item_i,
  input  wire logic                       result_valid_o,
  input  wire stks_pkg::out_t             result_o
);

  // results appear only during a drain run, and every drain cycle carries one
  `STKS_ASSERT_NOW(a_valid_is_busy, result_valid_o != busy, 1'b0)

  // an accepted last transaction always starts a result run
  `STKS_ASSERT_NEXT(a_last_starts_run, start && !busy && item_i.last, result_valid_o)

  // a transaction without last never produces a result
  `STKS_ASSERT_NEXT(a_no_last_no_run, !busy && !(start && item_i.last), !result_valid_o)

  // the run ends right after its marked final result
  `STKS_ASSERT_NEXT(a_end_closes_run, result_valid_o && result_o.end_of_list, !busy)

endmodule

bind streaming_top_k_selector_top stks_checker u_stks_checker (.*);

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for streaming_top_k_selector_top: directed table and
// random vectors, checked against a top-k ladder predictor kept in this file or typed-in results.
// Depends on stks_pkg and the streaming_top_k_selector_top RTL.
`timescale 1ns / 1ps

module tb_top;
  import stks_pkg::*;

  localparam int unsigned KMax       = 16;
  localparam int unsigned RandItems  = 385;
  localparam int unsigned CalmTail   = 60;    // last items of the run go without idling
  localparam int unsigned HoldOff    = 4;     // quiet cycles before a k_in_use write
  localparam int unsigned DrainWait  = KMax + 8;
  localparam int unsigned CycleLimit = 1_500_000;

  // score shapes for one random vector
  typedef enum int unsigned {
    SC_FULL,      // any 32-bit value
    SC_TIES,      // few distinct values, lots of equal scores
    SC_EXTREME,   // max, min, zero, -1 LSB
    SC_RISE,      // ascending ramp, every new score climbs to the top until the sum wraps
    SC_FALL       // descending ramp, every new score lands at the bottom until the sum wraps
  } score_mode_e;

  // one row of the directed table
  typedef struct {
    bit                       cfg_we;    // write k_in_use before this transaction
    logic [KCfgW-1:0]         cfg_val;
    logic signed [ScoreW-1:0] score;
    bit                       last;
    bit                       has_exp;   // single result typed in below
    out_t                     exp_res;
  } row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  in_t              item_i      = '0;
  logic             result_valid_o;
  out_t             result_o;
  logic             cfg_we_i    = 1'b0;
  logic [KCfgW-1:0] cfg_wdata_i = '0;

  // 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  streaming_top_k_selector_top #(
    .K(KMax)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // Predictor: a descending ladder of the best scores seen in the current vector.
  // ---------------------------------------------------------------------------
  logic signed [ScoreW-1:0] ladder_val [KMax];
  logic [PosW-1:0]          ladder_pos [KMax];
  logic [KCfgW-1:0]         ladder_cnt = '0;
  logic [PosW-1:0]          pos_ctr    = '0;
  logic [KCfgW-1:0]         k_reg      = KInUseReset;

  out_t pending_results [$];   // results the block still owes, oldest first
  row_t stim_rows [$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;

  // k_in_use as the block applies it: 0 acts as 1, above K acts as K
  function automatic int unsigned k_applied();
    int unsigned k;
    k = k_reg;
    if (k < 1) k = 1;
    if (k > KMax) k = KMax;
    return k;
  endfunction

  // Rank one accepted transaction into the ladder; on last, flush the ladder into
  // the result queue (unless the row carries its own typed expectation).
  task automatic rank_and_flush(input in_t it, input bit publish);
    int unsigned k, j;
    out_t r;
    k = k_applied();
    // a lowered k trims the tail before the new score is looked at
    if (ladder_cnt > k) ladder_cnt = KCfgW'(k);
    // full ladder: a score not above the smallest kept one is dropped
    if (!(ladder_cnt == k && it.score <= ladder_val[k-1])) begin
      j = (ladder_cnt < k) ? ladder_cnt : k - 1;
      // strictly-less test: equal scores stay ahead, so the earlier position wins
      while (j > 0 && ladder_val[j-1] < it.score) begin
        ladder_val[j] = ladder_val[j-1];
        ladder_pos[j] = ladder_pos[j-1];
        j--;
      end
      ladder_val[j] = it.score;
      ladder_pos[j] = pos_ctr;
      if (ladder_cnt < k) ladder_cnt++;
    end
    // position saturates on very long vectors
    if (pos_ctr != MaxPos) pos_ctr++;
    if (it.last) begin
      if (publish) begin
        for (int unsigned i = 0; i < ladder_cnt; i++) begin
          r.position    = ladder_pos[i];
          r.kept_score  = ladder_val[i];
          r.end_of_list = (i + 1 == ladder_cnt);
          pending_results.push_back(r);
        end
      end
      ladder_cnt = '0;
      pos_ctr    = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver side
  // ---------------------------------------------------------------------------

  // Present one transaction and hold it until start & !busy at a rising edge.
  // busy is sampled before the edge updates land, so the acceptance is race-free.
  task automatic push_item(input in_t it, input bit publish);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    rank_and_flush(it, publish);
  endtask

  // Sender gap with start held low.
  task automatic idle_burst();
    int unsigned n;
    n = $urandom_range(1, 16);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // k_in_use is written only with no result owed and the block quiet.
  task automatic write_k(input logic [KCfgW-1:0] val);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk_i);
    repeat (HoldOff) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    k_reg = val;
  endtask

  task automatic add_row(input bit cfg_we, input logic [KCfgW-1:0] cfg_val,
                         input logic signed [ScoreW-1:0] score, input bit last,
                         input bit has_exp, input out_t exp_res);
    row_t r;
    r.cfg_we  = cfg_we;
    r.cfg_val = cfg_val;
    r.score   = score;
    r.last    = last;
    r.has_exp = has_exp;
    r.exp_res = exp_res;
    stim_rows.push_back(r);
  endtask

  function automatic logic [KCfgW-1:0] pick_k();
    case ($urandom_range(0, 5))
      0:       return 5'd0;
      1:       return 5'd1;
      2:       return 5'd31;
      3:       return 5'd16;
      default: return KCfgW'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic logic signed [ScoreW-1:0] pick_score(input score_mode_e mode,
                                                          input logic signed [ScoreW-1:0] base,
                                                          input logic signed [ScoreW-1:0] step,
                                                          input int unsigned idx);
    case (mode)
      SC_TIES:    return (ScoreW'($urandom_range(0, 16)) - 32'sd8) <<< 16;
      SC_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7fff_ffff;
          1:       return 32'sh8000_0000;
          2:       return 32'sh0000_0000;
          default: return 32'shffff_ffff;
        endcase
      end
      SC_RISE:    return base + step * ScoreW'(idx);
      SC_FALL:    return base - step * ScoreW'(idx);
      default:    return ScoreW'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobed result must match the oldest owed one.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with none owed: position %0d score %0h end %0b",
                   result_o.position, result_o.kept_score, result_o.end_of_list);
      end else begin
        want = pending_results.pop_front();
        if (result_o.position !== want.position || result_o.kept_score !== want.kept_score ||
            result_o.end_of_list !== want.end_of_list) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected pos %0d score %0h end %0b, ",
                     want.position, want.kept_score, want.end_of_list,
                     "got pos %0d score %0h end %0b",
                     result_o.position, result_o.kept_score, result_o.end_of_list);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("** streaming_top_k_selector_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    in_t                      it;
    int unsigned              sent;
    int unsigned              len;
    int                       mid;
    score_mode_e              mode;
    logic signed [ScoreW-1:0] base;
    logic signed [ScoreW-1:0] step;

    // single reset at the start of the run
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Columns: cfg write?, k_in_use, score, last, typed?, typed result.
    // One-entry runs at reset k and at k = 1 are typed in; the rest go through the predictor.
    add_row(0, 5'd0,  32'sh7fff_ffff, 1, 1, '{position: 18'd0, kept_score: 32'sh7fff_ffff,
                                              end_of_list: 1'b1});
    add_row(0, 5'd0,  32'sh8000_0000, 1, 1, '{position: 18'd0, kept_score: 32'sh8000_0000,
                                              end_of_list: 1'b1});
    // zero k behaves as one; the second 9.0 ties and loses to the first
    add_row(1, 5'd0,  32'sh0005_0000, 0, 0, '0);
    add_row(0, 5'd0,  32'sh0009_0000, 0, 0, '0);
    add_row(0, 5'd0,  32'sh0009_0000, 0, 0, '0);
    add_row(0, 5'd0,  32'shfffd_0000, 0, 0, '0);
    add_row(0, 5'd0,  32'sh0002_0000, 1, 1, '{position: 18'd1, kept_score: 32'sh0009_0000,
                                              end_of_list: 1'b1});
    // k above K clamps to K; three equal scores keep arrival order
    add_row(1, 5'd31, 32'sh0001_0000, 0, 0, '0);
    add_row(0, 5'd0,  32'sh0001_0000, 0, 0, '0);
    add_row(0, 5'd0,  32'sh0001_0000, 1, 0, '0);
    // k = 2 with extreme scores
    add_row(1, 5'd2,  32'sh8000_0000, 0, 0, '0);
    add_row(0, 5'd0,  32'sh8000_0000, 0, 0, '0);
    add_row(0, 5'd0,  32'sh7fff_ffff, 0, 0, '0);
    add_row(0, 5'd0,  32'sh0000_0000, 1, 0, '0);
    // k lowered from 16 to 2 in the middle of a vector
    add_row(1, 5'd16, 32'sh0001_0000, 0, 0, '0);
    add_row(0, 5'd0,  32'sh0002_0000, 0, 0, '0);
    add_row(0, 5'd0,  32'sh0003_0000, 0, 0, '0);
    add_row(0, 5'd0,  32'sh0004_0000, 0, 0, '0);
    add_row(1, 5'd2,  32'sh0000_8000, 1, 0, '0);
    // full list: smaller and equal-to-smallest scores are dropped
    add_row(1, 5'd3,  32'sh000a_0000, 0, 0, '0);
    add_row(0, 5'd0,  32'sh0014_0000, 0, 0, '0);
    add_row(0, 5'd0,  32'sh001e_0000, 0, 0, '0);
    add_row(0, 5'd0,  32'sh0005_0000, 0, 0, '0);
    add_row(0, 5'd0,  32'sh000a_0000, 0, 0, '0);
    add_row(0, 5'd0,  32'sh0001_0000, 1, 0, '0);

    foreach (stim_rows[r]) begin
      if (stim_rows[r].cfg_we) write_k(stim_rows[r].cfg_val);
      it.score = stim_rows[r].score;
      it.last  = stim_rows[r].last;
      push_item(it, !stim_rows[r].has_exp);
      if (stim_rows[r].has_exp) pending_results.push_back(stim_rows[r].exp_res);
    end

    // Random vectors: mostly short, some longer than K; k changed between vectors
    // and now and then set to a value from 0 to 4 mid-vector.
    sent = 0;
    while (sent < RandItems) begin
      if ($urandom_range(0, 2) == 0) write_k(pick_k());
      len  = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      mode = score_mode_e'($urandom_range(0, 4));
      base = ScoreW'($urandom());
      step = ScoreW'($urandom_range(1, 1 << 20));
      mid  = (len > 2 && $urandom_range(0, 9) == 0) ? int'($urandom_range(1, len - 1)) : -1;
      for (int unsigned i = 0; i < len; i++) begin
        if (int'(i) == mid) write_k(KCfgW'($urandom_range(0, 4)));
        if (sent + CalmTail < RandItems && $urandom_range(0, 3) == 0) idle_burst();
        it.score = pick_score(mode, base, step, i);
        it.last  = (i == len - 1);
        push_item(it, 1'b1);
        sent++;
      end
    end

    // drain: wait for every owed result, then keep watching for stray results
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** streaming_top_k_selector_top: PASSED **");
    end else begin
      $display("** streaming_top_k_selector_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- streaming_top_k_selector_top.f -----
+incdir+sv
sv/stks_pkg.sv
sv/stks_cell.sv
sv/streaming_top_k_selector_top.sv
sv/stks_checker.sv
verif/tb_top.sv
